FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, ignored while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/psd_pkg.sv
// Types and constants for the point-to-segment distance pipeline.
`timescale 1ns / 1ps

package psd_pkg;

    localparam int COORD_W   = 32;
    localparam int D_W       = COORD_W + 1;   // coordinate difference
    localparam int P_W       = 2 * D_W;       // product of two differences
    localparam int DOT_W     = P_W + 1;       // signed dot product
    localparam int LEN_W     = P_W;           // squared length
    localparam int Q_W       = D_W;           // division quotient and multiplier
    localparam int DIST_W    = COORD_W + 1;
    localparam int ROOT_W    = P_W / 2;
    localparam int REM_W     = ROOT_W + 3;
    localparam int DIV_STEPS = Q_W;

    typedef struct packed {
        logic signed [COORD_W-1:0] query_x;
        logic signed [COORD_W-1:0] query_y;
        logic signed [COORD_W-1:0] segment_start_x;
        logic signed [COORD_W-1:0] segment_start_y;
        logic signed [COORD_W-1:0] segment_end_x;
        logic signed [COORD_W-1:0] segment_end_y;
    } psd_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] closest_x;
        logic signed [COORD_W-1:0] closest_y;
        logic [DIST_W-1:0]         distance;
        logic                      degenerate;
    } psd_out_t;

    // Carried alongside the divider.
    typedef struct packed {
        logic signed [COORD_W-1:0] qx;
        logic signed [COORD_W-1:0] qy;
        logic signed [COORD_W-1:0] base_x;
        logic signed [COORD_W-1:0] base_y;
        logic                      neg_x;
        logic                      neg_y;
        logic                      interior;
        logic                      degenerate;
    } psd_side_t;

    typedef struct packed {
        logic [LEN_W-1:0] dot;
        logic [LEN_W-1:0] len2;
        logic [LEN_W-1:0] rx;
        logic [LEN_W-1:0] ry;
        logic [Q_W-1:0]   mx;
        logic [Q_W-1:0]   my;
        logic [Q_W-1:0]   qtx;
        logic [Q_W-1:0]   qty;
        psd_side_t        side;
    } psd_div_t;

    typedef struct packed {
        logic [LEN_W-1:0] r;
        logic [1:0]       d;
    } psd_dstep_t;

    // Carried alongside the square root.
    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic                      degenerate;
    } psd_res_t;

    typedef struct packed {
        logic [P_W-1:0]    rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        psd_res_t          res;
    } psd_sq_t;

endpackage

FILE: rtl/point_segment_distance.sv
// Top level: pipelined closest point on a 2-D segment and distance to it.
`timescale 1ns / 1ps

// Takes one item per clock unless stalled, and returns one result item per
// item, in order. All arithmetic is exact integer work on the raw coordinates,
// so the position of the binary point does not matter. The projection ratio
// is formed by a restoring divider unrolled into 33 stages (one quotient
// digit of 0 to 2 per stage, a 68-bit add and two compares each), and the
// distance by a digit-by-digit square root unrolled into 33 stages; these two
// chains set the latency. Rate is one item per cycle while no result waits on
// a stall. A stall on a waiting valid result freezes the whole pipeline, and
// query_stall follows it in the same cycle. A segment whose end points
// coincide returns degenerate set with zero point and distance.
module point_segment_distance (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               query_valid,
    output logic               query_stall,
    input  psd_pkg::psd_in_t   query,
    output logic               result_valid,
    input  logic               result_stall,
    output psd_pkg::psd_out_t  result
);

    localparam int COORD_W   = psd_pkg::COORD_W;
    localparam int D_W       = psd_pkg::D_W;
    localparam int P_W       = psd_pkg::P_W;
    localparam int DOT_W     = psd_pkg::DOT_W;
    localparam int LEN_W     = psd_pkg::LEN_W;
    localparam int Q_W       = psd_pkg::Q_W;
    localparam int DIST_W    = psd_pkg::DIST_W;
    localparam int ROOT_W    = psd_pkg::ROOT_W;
    localparam int REM_W     = psd_pkg::REM_W;
    localparam int DIV_STEPS = psd_pkg::DIV_STEPS;
    // s1, s2, s3, s4, divider, round, point, error, square, sum, root, output
    localparam int LAT       = 4 + DIV_STEPS + 5 + ROOT_W + 1;

    // One divider step: bring in the next multiplier bit, subtract up to
    // twice the squared length.
    function automatic psd_pkg::psd_dstep_t div_step(
        input logic [LEN_W-1:0] r,
        input logic [LEN_W-1:0] dot,
        input logic [LEN_W-1:0] len2,
        input logic             b
    );
        logic [LEN_W+1:0]    t;
        logic [LEN_W+1:0]    l1;
        logic [LEN_W+1:0]    l2;
        psd_pkg::psd_dstep_t s;
        t  = ((LEN_W+2)'(r) << 1) + (b ? (LEN_W+2)'(dot) : '0);
        l1 = (LEN_W+2)'(len2);
        l2 = l1 << 1;
        if (t >= l2)
        begin
            s.r = LEN_W'(t - l2);
            s.d = 2'd2;
        end
        else if (t >= l1)
        begin
            s.r = LEN_W'(t - l1);
            s.d = 2'd1;
        end
        else
        begin
            s.r = LEN_W'(t);
            s.d = 2'd0;
        end
        return s;
    endfunction

    // Hold every stage while a finished result waits on a stalled consumer.
    logic en;
    logic [LAT-1:0] vld_reg;

    assign en           = !(vld_reg[LAT-1] && result_stall);
    assign query_stall  = !en;
    assign result_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], query_valid};
        end
    end

    // Stage 1: differences against the start point.
    psd_pkg::psd_in_t          s1_pts_reg;
    logic signed [D_W-1:0]     s1_dx_reg, s1_dy_reg, s1_ux_reg, s1_uy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_pts_reg <= query;
            s1_dx_reg  <= D_W'(query.segment_end_x) - D_W'(query.segment_start_x);
            s1_dy_reg  <= D_W'(query.segment_end_y) - D_W'(query.segment_start_y);
            s1_ux_reg  <= D_W'(query.query_x) - D_W'(query.segment_start_x);
            s1_uy_reg  <= D_W'(query.query_y) - D_W'(query.segment_start_y);
        end
    end

    // Stage 2: the four products, magnitudes and the degenerate test.
    psd_pkg::psd_in_t          s2_pts_reg;
    logic signed [P_W-1:0]     s2_px_reg, s2_py_reg, s2_lx_reg, s2_ly_reg;
    logic [Q_W-1:0]            s2_mx_reg, s2_my_reg;
    logic                      s2_negx_reg, s2_negy_reg, s2_deg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_pts_reg  <= s1_pts_reg;
            s2_px_reg   <= P_W'(s1_ux_reg) * P_W'(s1_dx_reg);
            s2_py_reg   <= P_W'(s1_uy_reg) * P_W'(s1_dy_reg);
            s2_lx_reg   <= P_W'(s1_dx_reg) * P_W'(s1_dx_reg);
            s2_ly_reg   <= P_W'(s1_dy_reg) * P_W'(s1_dy_reg);
            s2_mx_reg   <= Q_W'($unsigned(s1_dx_reg[D_W-1] ? -s1_dx_reg : s1_dx_reg));
            s2_my_reg   <= Q_W'($unsigned(s1_dy_reg[D_W-1] ? -s1_dy_reg : s1_dy_reg));
            s2_negx_reg <= s1_dx_reg[D_W-1];
            s2_negy_reg <= s1_dy_reg[D_W-1];
            s2_deg_reg  <= (s1_dx_reg == '0) && (s1_dy_reg == '0);
        end
    end

    // Stage 3: dot product and squared length.
    psd_pkg::psd_in_t          s3_pts_reg;
    logic signed [DOT_W-1:0]   s3_dot_reg;
    logic [LEN_W-1:0]          s3_len2_reg;
    logic [Q_W-1:0]            s3_mx_reg, s3_my_reg;
    logic                      s3_negx_reg, s3_negy_reg, s3_deg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_pts_reg  <= s2_pts_reg;
            s3_dot_reg  <= DOT_W'(s2_px_reg) + DOT_W'(s2_py_reg);
            s3_len2_reg <= $unsigned(s2_lx_reg + s2_ly_reg);
            s3_mx_reg   <= s2_mx_reg;
            s3_my_reg   <= s2_my_reg;
            s3_negx_reg <= s2_negx_reg;
            s3_negy_reg <= s2_negy_reg;
            s3_deg_reg  <= s2_deg_reg;
        end
    end

    // Stage 4: decide start, end or interior, and load the divider.
    psd_pkg::psd_div_t div_reg [0:DIV_STEPS];
    psd_pkg::psd_div_t div_next [0:DIV_STEPS];
    logic              s4_before, s4_after;

    always_comb
    begin
        s4_before = (s3_dot_reg <= 0);
        s4_after  = !s4_before && ($unsigned(s3_dot_reg) >= DOT_W'(s3_len2_reg));
        div_next[0].dot             = LEN_W'($unsigned(s3_dot_reg));
        div_next[0].len2            = s3_len2_reg;
        div_next[0].rx              = '0;
        div_next[0].ry              = '0;
        div_next[0].mx              = s3_mx_reg;
        div_next[0].my              = s3_my_reg;
        div_next[0].qtx             = '0;
        div_next[0].qty             = '0;
        div_next[0].side.qx         = s3_pts_reg.query_x;
        div_next[0].side.qy         = s3_pts_reg.query_y;
        div_next[0].side.base_x     = s4_after ? s3_pts_reg.segment_end_x
                                               : s3_pts_reg.segment_start_x;
        div_next[0].side.base_y     = s4_after ? s3_pts_reg.segment_end_y
                                               : s3_pts_reg.segment_start_y;
        div_next[0].side.neg_x      = s3_negx_reg;
        div_next[0].side.neg_y      = s3_negy_reg;
        div_next[0].side.interior   = !s4_before && !s4_after;
        div_next[0].side.degenerate = s3_deg_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg[0] <= div_next[0];
        end
    end

    // Divider: one quotient digit (0 to 2) per stage for both coordinates.
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        psd_pkg::psd_dstep_t sx, sy;

        always_comb
        begin
            sx = div_step(div_reg[k].rx, div_reg[k].dot, div_reg[k].len2,
                          div_reg[k].mx[Q_W-1]);
            sy = div_step(div_reg[k].ry, div_reg[k].dot, div_reg[k].len2,
                          div_reg[k].my[Q_W-1]);
            div_next[k+1]     = div_reg[k];
            div_next[k+1].rx  = sx.r;
            div_next[k+1].ry  = sy.r;
            div_next[k+1].mx  = div_reg[k].mx << 1;
            div_next[k+1].my  = div_reg[k].my << 1;
            div_next[k+1].qtx = (div_reg[k].qtx << 1) + Q_W'(sx.d);
            div_next[k+1].qty = (div_reg[k].qty << 1) + Q_W'(sy.d);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_reg[k+1] <= div_next[k+1];
            end
        end
    end

    // Round stage: round the quotient half up.
    psd_pkg::psd_side_t rd_side_reg;
    logic [Q_W-1:0]     rd_ox_reg, rd_oy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_side_reg <= div_reg[DIV_STEPS].side;
            rd_ox_reg   <= div_reg[DIV_STEPS].qtx + Q_W'(((LEN_W+1)'(div_reg[DIV_STEPS].rx) << 1)
                           >= (LEN_W+1)'(div_reg[DIV_STEPS].len2));
            rd_oy_reg   <= div_reg[DIV_STEPS].qty + Q_W'(((LEN_W+1)'(div_reg[DIV_STEPS].ry) << 1)
                           >= (LEN_W+1)'(div_reg[DIV_STEPS].len2));
        end
    end

    // Point stage: an end point, or a step from the start towards the end.
    logic signed [D_W:0]       pt_offx, pt_offy, pt_cxw, pt_cyw;
    logic signed [COORD_W-1:0] pt_cx_reg, pt_cy_reg, pt_qx_reg, pt_qy_reg;
    logic                      pt_deg_reg;

    always_comb
    begin
        pt_offx = rd_side_reg.interior ? $signed((D_W+1)'(rd_ox_reg)) : '0;
        pt_offy = rd_side_reg.interior ? $signed((D_W+1)'(rd_oy_reg)) : '0;
        pt_cxw  = (D_W+1)'(rd_side_reg.base_x) + (rd_side_reg.neg_x ? -pt_offx : pt_offx);
        pt_cyw  = (D_W+1)'(rd_side_reg.base_y) + (rd_side_reg.neg_y ? -pt_offy : pt_offy);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt_cx_reg  <= pt_cxw[COORD_W-1:0];
            pt_cy_reg  <= pt_cyw[COORD_W-1:0];
            pt_qx_reg  <= rd_side_reg.qx;
            pt_qy_reg  <= rd_side_reg.qy;
            pt_deg_reg <= rd_side_reg.degenerate;
        end
    end

    // Error stage: vector from the closest point to the query.
    psd_pkg::psd_res_t     er_res_reg;
    logic signed [D_W-1:0] er_ex_reg, er_ey_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            er_res_reg.cx         <= pt_cx_reg;
            er_res_reg.cy         <= pt_cy_reg;
            er_res_reg.degenerate <= pt_deg_reg;
            er_ex_reg             <= D_W'(pt_qx_reg) - D_W'(pt_cx_reg);
            er_ey_reg             <= D_W'(pt_qy_reg) - D_W'(pt_cy_reg);
        end
    end

    // Square stage.
    psd_pkg::psd_res_t     sqr_res_reg;
    logic signed [P_W-1:0] sqr_x_reg, sqr_y_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqr_res_reg <= er_res_reg;
            sqr_x_reg   <= P_W'(er_ex_reg) * P_W'(er_ex_reg);
            sqr_y_reg   <= P_W'(er_ey_reg) * P_W'(er_ey_reg);
        end
    end

    // Sum stage: load the square root.
    psd_pkg::psd_sq_t sq_reg [0:ROOT_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg[0].rad  <= $unsigned(sqr_x_reg + sqr_y_reg);
            sq_reg[0].rem  <= '0;
            sq_reg[0].root <= '0;
            sq_reg[0].res  <= sqr_res_reg;
        end
    end

    // Square root: one root bit per stage.
    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_sqrt
        logic [REM_W-1:0] rem2, trial;
        psd_pkg::psd_sq_t nxt;

        always_comb
        begin
            rem2  = {sq_reg[i].rem[REM_W-3:0], sq_reg[i].rad[P_W-1:P_W-2]};
            trial = REM_W'({sq_reg[i].root, 2'b01});
            nxt     = sq_reg[i];
            nxt.rad = sq_reg[i].rad << 2;
            if (rem2 >= trial)
            begin
                nxt.rem  = rem2 - trial;
                nxt.root = {sq_reg[i].root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                nxt.rem  = rem2;
                nxt.root = {sq_reg[i].root[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[i+1] <= nxt;
            end
        end
    end

    // Output stage: round the root to nearest, saturate, blank degenerates.
    logic [ROOT_W:0]   fin_rounded;
    logic [DIST_W-1:0] fin_dist;
    psd_pkg::psd_out_t out_next, out_reg;

    always_comb
    begin
        fin_rounded = (ROOT_W+1)'(sq_reg[ROOT_W].root)
                    + (ROOT_W+1)'(sq_reg[ROOT_W].rem > REM_W'(sq_reg[ROOT_W].root));
        fin_dist    = fin_rounded[ROOT_W] ? '1 : fin_rounded[DIST_W-1:0];
        if (sq_reg[ROOT_W].res.degenerate)
        begin
            out_next.closest_x  = '0;
            out_next.closest_y  = '0;
            out_next.distance   = '0;
            out_next.degenerate = 1'b1;
        end
        else
        begin
            out_next.closest_x  = sq_reg[ROOT_W].res.cx;
            out_next.closest_y  = sq_reg[ROOT_W].res.cy;
            out_next.distance   = fin_dist;
            out_next.degenerate = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign result = out_reg;

endmodule

FILE: rtl/psd_checker.sv
// Port-level checks for the point-to-segment distance pipeline.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module psd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              query_stall,
    input psd_pkg::psd_out_t result,
    input logic              result_valid,
    input logic              result_stall
);

    // hold a stalled result
    `ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result))

    // back-pressure only comes from a stalled result
    `ASSERT_IMPLIES(a_stall_source, clk, rst_n, query_stall, result_valid && result_stall)

    // degenerate items carry zero fields
    `ASSERT_IMPLIES(a_degenerate_zero, clk, rst_n, result_valid && result.degenerate, (result.closest_x == '0) && (result.closest_y == '0) && (result.distance == '0))

endmodule

bind point_segment_distance psd_checker u_psd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .query_stall  (query_stall),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
);
